FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define LAPEDGE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lapedge assertion failed");

// next-cycle implication, disabled while in reset
`define LAPEDGE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lapedge assertion failed");

`endif

FILE: rtl/lapedge_pkg.sv
// shared types, constants and the luminance function of the laplacian edge block
// no dependencies
`timescale 1ns / 1ps

package lapedge_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int CHAN_W      = 8;
    localparam int IN_TDATA_W  = 3 * CHAN_W;
    localparam int EDGE_W      = 8;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int OUT_TDATA_W = 32;

    localparam int LUMA_W    = 16;
    localparam int RING_ROWS = 4;
    localparam int RING_W    = RING_ROWS * LUMA_W;

    localparam logic [LUMA_W-1:0] LUMA_R_WT = 16'd77;
    localparam logic [LUMA_W-1:0] LUMA_G_WT = 16'd150;
    localparam logic [LUMA_W-1:0] LUMA_B_WT = 16'd29;

    typedef enum logic
    {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } command_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed
    {
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [EDGE_W-1:0] edge_value;
    } result_t;

    // luminance scaled by 256
    function automatic logic [LUMA_W-1:0] luma(input logic [CHAN_W-1:0] r,
                                               input logic [CHAN_W-1:0] g,
                                               input logic [CHAN_W-1:0] b);
        logic [LUMA_W-1:0] pr;
        logic [LUMA_W-1:0] pg;
        logic [LUMA_W-1:0] pb;
        pr = LUMA_W'(r) * LUMA_R_WT;
        pg = LUMA_W'(g) * LUMA_G_WT;
        pb = LUMA_W'(b) * LUMA_B_WT;
        return pr + pg + pb;
    endfunction

endpackage

FILE: rtl/lapedge_ram.sv
// generic synchronous ram: one lane-masked write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module lapedge_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    parameter int LANES = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LW = WIDTH / LANES
) (
    input  logic             clk,
    input  logic [LANES-1:0] we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re_a,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic             re_b,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (we[i])
            begin
                mem[waddr][i*LW +: LW] <= wdata[i*LW +: LW];
            end
        end
    end

    // read returns the contents before a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/laplacian_edge_luma_3x3_top.sv
// top level of the 3x3 laplacian edge detector on luminance
// depends on lapedge_pkg and lapedge_ram
`timescale 1ns / 1ps

// channel  dir  handshake              payload
// s_axis   in   tvalid / tready        tdata red, green, blue; tuser command
// m_axis   out  tvalid / tready        tdata edge, column, row; tlast frame end
// apb      in   psel, penable, pwrite  image_width at 0x0, image_height at 0x4
//
// one transfer per cycle unless the queue is full; the line memory has one write port
// and two read ports; results pass the read and window stage registers to the queue
// reset sets sizes, clears counters, queue and valids; line memory is never cleared
// a two-entry output queue lets input transfers continue while a result waits
// s_axis_tready drops only while both queue entries are full

module laplacian_edge_luma_3x3_top #(
    parameter int MAX_WIDTH  = lapedge_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lapedge_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lapedge_pkg::APB_AW-1:0]     paddr,
    input  logic [lapedge_pkg::APB_DW-1:0]     pwdata,
    output logic [lapedge_pkg::APB_DW-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lapedge_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // red, green, blue
    input  logic                               s_axis_tuser,   // command
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lapedge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // edge, column, row, pad
    output logic                               m_axis_tlast
);

    import lapedge_pkg::*;

    localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int YW0 = $clog2(MAX_HEIGHT + 1);
    localparam int YW  = (YW0 < 2) ? 2 : YW0;

    function automatic logic [LUMA_W-1:0] lane_pick(input logic [RING_W-1:0] q,
                                                    input logic [1:0] lane);
        return q[lane * LUMA_W +: LUMA_W];
    endfunction

    // configuration
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;
    logic                    cfg_wr;
    logic [XW-1:0]           w_used;
    logic [YW-1:0]           h_used;
    logic [XW-1:0]           w_last;
    logic [YW-1:0]           h_last;

    // position counters
    logic [XW-1:0] in_col_reg,  in_col_next;
    logic [YW-1:0] in_row_reg,  in_row_next;
    logic [XW-1:0] out_col_reg, out_col_next;
    logic [YW-1:0] out_row_reg, out_row_next;

    logic          adv;
    logic          s_fire;
    logic          pixel;
    logic          restart;
    logic [XW-1:0] base_in_col;
    logic [YW-1:0] base_in_row;
    logic [XW-1:0] in_col_inc;
    logic [XW-1:0] post_in_col;
    logic [YW-1:0] post_in_row;
    logic [XW-1:0] ox, ox_inc, nx;
    logic [YW-1:0] oy, oy_inc, ny, ym;
    logic          avail;
    logic          emit;
    logic          last_px;
    logic [LUMA_W-1:0] luma_val;
    logic [1:0]    wr_lane;

    // line memory ports
    logic [RING_ROWS-1:0] ram_we;
    logic [RING_W-1:0]    ram_rd_a;
    logic [RING_W-1:0]    ram_rd_b;

    // read stage
    logic              s1_valid_reg;
    logic              s1_first_reg;
    logic [1:0]        s1_lane_m_reg, s1_lane_c_reg, s1_lane_p_reg;
    logic [XW-1:0]     s1_col_reg;
    logic [YW-1:0]     s1_row_reg;
    logic              s1_last_reg;
    logic              s1_fwd_a_reg, s1_fwd_b_reg;
    logic [1:0]        s1_fwd_lane_reg;
    logic [LUMA_W-1:0] s1_fwd_data_reg;

    logic [RING_W-1:0] qa_fix, qb_fix;
    logic [LUMA_W-1:0] col_a [3];
    logic [LUMA_W-1:0] col_b [3];
    logic [LUMA_W-1:0] win_l_next [3];
    logic [LUMA_W-1:0] win_c_next [3];
    logic [LUMA_W-1:0] win_r_next [3];

    // window stage
    logic              s2_valid_reg;
    logic [LUMA_W-1:0] win_l_reg [3];
    logic [LUMA_W-1:0] win_c_reg [3];
    logic [LUMA_W-1:0] win_r_reg [3];
    logic [XW-1:0]     s2_col_reg;
    logic [YW-1:0]     s2_row_reg;
    logic              s2_last_reg;

    logic [LUMA_W+2:0] pos_sum, neg_sum, mag;
    result_t           res;

    // output queue
    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMAGE_WIDTH_RST;
            image_height_reg <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        if (image_width_reg == '0)
            w_used = XW'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_used = XW'(MAX_WIDTH);
        else
            w_used = XW'(image_width_reg);

        if (image_height_reg == '0)
            h_used = YW'(1);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_used = YW'(MAX_HEIGHT);
        else
            h_used = YW'(image_height_reg);

        w_last = w_used - 1'b1;
        h_last = h_used - 1'b1;
    end

    // item decode, write position and release of the next result
    assign adv           = (cnt_reg != 2'd2);
    assign s_axis_tready = adv;

    always_comb
    begin
        s_fire  = s_axis_tvalid & adv;
        pixel   = s_fire & (command_t'(s_axis_tuser) == CMD_PIXEL);
        restart = pixel & (in_row_reg == h_used);

        base_in_col = restart ? '0 : in_col_reg;
        base_in_row = restart ? '0 : in_row_reg;
        ox          = restart ? '0 : out_col_reg;
        oy          = restart ? '0 : out_row_reg;

        in_col_inc  = base_in_col + 1'b1;
        post_in_col = base_in_col;
        post_in_row = base_in_row;
        if (pixel)
        begin
            if (in_col_inc == w_used)
            begin
                post_in_col = '0;
                post_in_row = base_in_row + 1'b1;
            end
            else
            begin
                post_in_col = in_col_inc;
            end
        end

        ox_inc  = ox + 1'b1;
        oy_inc  = oy + 1'b1;
        nx      = (ox_inc < w_used) ? ox_inc : w_last;
        ny      = (oy_inc < h_used) ? oy_inc : h_last;
        ym      = (oy == '0) ? '0 : oy - 1'b1;
        avail   = (ny < post_in_row) || ((ny == post_in_row) && (nx < post_in_col));
        emit    = s_fire & (oy != h_used) & avail;
        last_px = (ox == w_last) && (oy == h_last);

        out_col_next = ox;
        out_row_next = oy;
        if (emit)
        begin
            if (ox_inc == w_used)
            begin
                out_col_next = '0;
                out_row_next = oy_inc;
            end
            else
            begin
                out_col_next = ox_inc;
            end
        end
        in_col_next = post_in_col;
        in_row_next = post_in_row;

        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end

        luma_val = luma(s_axis_tdata[CHAN_W-1:0], s_axis_tdata[2*CHAN_W-1:CHAN_W],
                        s_axis_tdata[3*CHAN_W-1:2*CHAN_W]);
        wr_lane  = base_in_row[1:0];
        ram_we   = pixel ? (RING_ROWS'(1) << wr_lane) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // port a fetches the right-hand column, port b column zero for a row start
    lapedge_ram #(
        .WIDTH (RING_W),
        .DEPTH (MAX_WIDTH),
        .LANES (RING_ROWS)
    ) u_line_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (base_in_col[AW-1:0]),
        .wdata   ({RING_ROWS{luma_val}}),
        .re_a    (emit),
        .raddr_a (nx[AW-1:0]),
        .rdata_a (ram_rd_a),
        .re_b    (emit),
        .raddr_b ('0),
        .rdata_b (ram_rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_first_reg    <= (ox == '0);
            s1_lane_m_reg   <= ym[1:0];
            s1_lane_c_reg   <= oy[1:0];
            s1_lane_p_reg   <= ny[1:0];
            s1_col_reg      <= ox;
            s1_row_reg      <= oy;
            s1_last_reg     <= last_px;
            s1_fwd_a_reg    <= pixel && (base_in_col == nx);
            s1_fwd_b_reg    <= pixel && (base_in_col == '0);
            s1_fwd_lane_reg <= wr_lane;
            s1_fwd_data_reg <= luma_val;
        end
    end

    // same-cycle write bypass, row selection and window shift
    always_comb
    begin
        qa_fix = ram_rd_a;
        qb_fix = ram_rd_b;
        if (s1_fwd_a_reg)
            qa_fix[s1_fwd_lane_reg * LUMA_W +: LUMA_W] = s1_fwd_data_reg;
        if (s1_fwd_b_reg)
            qb_fix[s1_fwd_lane_reg * LUMA_W +: LUMA_W] = s1_fwd_data_reg;

        col_a[0] = lane_pick(qa_fix, s1_lane_m_reg);
        col_a[1] = lane_pick(qa_fix, s1_lane_c_reg);
        col_a[2] = lane_pick(qa_fix, s1_lane_p_reg);
        col_b[0] = lane_pick(qb_fix, s1_lane_m_reg);
        col_b[1] = lane_pick(qb_fix, s1_lane_c_reg);
        col_b[2] = lane_pick(qb_fix, s1_lane_p_reg);

        for (int i = 0; i < 3; i++)
        begin
            if (s1_first_reg)
            begin
                win_l_next[i] = col_b[i];
                win_c_next[i] = col_b[i];
            end
            else
            begin
                win_l_next[i] = win_c_reg[i];
                win_c_next[i] = win_r_reg[i];
            end
            win_r_next[i] = col_a[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_l_reg[i] <= win_l_next[i];
                win_c_reg[i] <= win_c_next[i];
                win_r_reg[i] <= win_r_next[i];
            end
            s2_col_reg  <= s1_col_reg;
            s2_row_reg  <= s1_row_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // laplacian, magnitude, scale and saturate
    always_comb
    begin
        pos_sum = {win_c_reg[1], 3'b000};
        neg_sum = (LUMA_W+3)'(win_l_reg[0]) + (LUMA_W+3)'(win_l_reg[1])
                + (LUMA_W+3)'(win_l_reg[2]) + (LUMA_W+3)'(win_c_reg[0])
                + (LUMA_W+3)'(win_c_reg[2]) + (LUMA_W+3)'(win_r_reg[0])
                + (LUMA_W+3)'(win_r_reg[1]) + (LUMA_W+3)'(win_r_reg[2]);
        mag     = (pos_sum >= neg_sum) ? pos_sum - neg_sum : neg_sum - pos_sum;

        res.edge_value = (|mag[LUMA_W+2:LUMA_W]) ? '1 : mag[LUMA_W-1:8];
        res.col        = COL_W'(s2_col_reg);
        res.row        = ROW_W'(s2_row_reg);
        res.last       = s2_last_reg;
    end

    // two-entry output queue
    assign push = adv & s2_valid_reg;
    assign pop  = m_axis_tvalid & m_axis_tready;

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                    q0_next = res;
                else
                    q1_next = res;
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01:
            begin
                q0_next  = q1_reg;
                cnt_next = cnt_reg - 2'd1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    q0_next = res;
                end
                else
                begin
                    q0_next = q1_reg;
                    q1_next = res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = OUT_TDATA_W'({q0_reg.row, q0_reg.col, q0_reg.edge_value});
    assign m_axis_tlast  = q0_reg.last;

endmodule

FILE: rtl/lapedge_checker.sv
// port-level checker for the laplacian edge top level, bound to it below
// depends on lapedge_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lapedge_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [lapedge_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                                m_axis_tlast
);

    // a stalled result holds
    `LAPEDGE_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // input backpressure only with a full queue, so a result must be showing
    `LAPEDGE_ASSERT_IMP(a_stall_has_result, clk, rst_n, !s_axis_tready, m_axis_tvalid)

    // the queue fills only through a cycle in which its head was not taken
    `LAPEDGE_ASSERT_IMP(a_stall_cause, clk, rst_n, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready))

    // one result transfer out of a full queue frees the input side
    `LAPEDGE_ASSERT_NXT(a_stall_release, clk, rst_n, !s_axis_tready && m_axis_tvalid && m_axis_tready, s_axis_tready)

endmodule

bind laplacian_edge_luma_3x3_top lapedge_checker u_lapedge_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
